// ----- rtl/core/ntl_pkg.sv -----
// Shared types, constants and codes of the NTC thermistor linearizer.
package ntl_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    // Field widths
    localparam int OFFSET_W  = 10;
    localparam int GAIN_W    = 16;
    localparam int ROWS_W    = 7;
    localparam int INDEX_W   = 6;
    localparam int TEMP_W    = 16;
    localparam int RES_W     = 24;
    localparam int READING_W = 20;

    // APB side
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Shared divider: dividend and divisor widths
    localparam int DIV_NUM_W = 43;
    localparam int DIV_DEN_W = 25;

    localparam logic [GAIN_W-1:0]        GAIN_RESET = 16'd16384;
    localparam logic signed [TEMP_W-1:0] START_TEMP = -16'sd10240;
    localparam logic [RES_W-1:0]         START_RES  = 24'd2738094;
    localparam logic [RES_W-1:0]         RES_MAX    = 24'hFFFFFF;

    typedef enum logic [1:0] {
        REG_ADC_OFFSET = 2'd0,
        REG_ADC_GAIN   = 2'd1,
        REG_TABLE_ROWS = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_index_t;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_CONVERT = 1'b1
    } op_t;

    typedef enum logic {
        ST_INTERPOLATED = 1'b0,
        ST_NO_SEGMENT   = 1'b1
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORR,
        S_RDIV_START,
        S_RDIV_WAIT,
        S_SCAN,
        S_MUL,
        S_IDIV_START,
        S_IDIV_WAIT,
        S_FIN
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] adc_offset;
        logic [GAIN_W-1:0]   adc_gain;
        logic [ROWS_W-1:0]   table_rows;
    } cfg_t;

endpackage

// ----- rtl/core/ntl_in_if.sv -----
// Input channel: valid/ready handshake with load and convert payload.
interface ntl_in_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic [ntl_pkg::INDEX_W-1:0]         row_index;
    logic signed [ntl_pkg::TEMP_W-1:0]   row_temperature;
    logic [ntl_pkg::RES_W-1:0]           row_resistance;
    logic [ntl_pkg::READING_W-1:0]       adc_reading;

    modport source (
        output valid, operation, row_index, row_temperature, row_resistance, adc_reading,
        input  ready
    );
    modport sink (
        input  valid, operation, row_index, row_temperature, row_resistance, adc_reading,
        output ready
    );
endinterface

// ----- rtl/core/ntl_out_if.sv -----
// Output channel: valid/ready handshake with conversion result payload.
interface ntl_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ntl_pkg::TEMP_W-1:0]   temperature;
    logic [ntl_pkg::RES_W-1:0]           resistance;
    logic                                status;

    modport source (
        output valid, temperature, resistance, status,
        input  ready
    );
    modport sink (
        input  valid, temperature, resistance, status,
        output ready
    );
endinterface

// ----- rtl/core/ntl_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module ntl_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ntl_pkg::div_req_t req,
    output ntl_pkg::div_rsp_t rsp
);
    localparam int NW = ntl_pkg::DIV_NUM_W;
    localparam int VW = ntl_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic [VW-1:0] rem_reg,  rem_next;
    logic [NW-1:0] quo_reg,  quo_next;
    logic [VW-1:0] den_reg,  den_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   trial;
    logic          fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NW-1]};
        fits  = trial >= {1'b0, den_reg};
    end

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            den_next  = req.divisor;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when the divisor fits
            rem_next = fits ? VW'(trial - {1'b0, den_reg}) : trial[VW-1:0];
            quo_next = {quo_reg[NW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- rtl/core/ntl_table.sv -----
// NTC table memory: one write port, one registered read port.
module ntl_table #(
    parameter int DEPTH = ntl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [$clog2(DEPTH)-1:0]          wr_addr,
    input  logic signed [ntl_pkg::TEMP_W-1:0] wr_temp,
    input  logic [ntl_pkg::RES_W-1:0]         wr_res,
    input  logic                              rd_en,
    input  logic [$clog2(DEPTH)-1:0]          rd_addr,
    output logic signed [ntl_pkg::TEMP_W-1:0] rd_temp,
    output logic [ntl_pkg::RES_W-1:0]         rd_res
);
    logic [ntl_pkg::TEMP_W+ntl_pkg::RES_W-1:0] mem [DEPTH];
    logic [ntl_pkg::TEMP_W+ntl_pkg::RES_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_temp, wr_res};
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign rd_temp = $signed(rd_reg[ntl_pkg::TEMP_W+ntl_pkg::RES_W-1:ntl_pkg::RES_W]);
    assign rd_res  = rd_reg[ntl_pkg::RES_W-1:0];

endmodule

// ----- rtl/core/ntl_regs.sv -----
// APB configuration registers: ADC offset, ADC gain, table row count.
module ntl_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ntl_pkg::PADDR_W-1:0]  paddr,
    input  logic [ntl_pkg::PDATA_W-1:0]  pwdata,
    output logic [ntl_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output ntl_pkg::cfg_t                cfg
);
    ntl_pkg::reg_index_t idx;
    logic                wr;
    logic [ntl_pkg::OFFSET_W-1:0] offset_reg, offset_next;
    logic [ntl_pkg::GAIN_W-1:0]   gain_reg,   gain_next;
    logic [ntl_pkg::ROWS_W-1:0]   rows_reg,   rows_next;

    assign pready = 1'b1;
    assign idx    = ntl_pkg::reg_index_t'(paddr[3:2]);
    assign wr     = psel && penable && pwrite && pready;

    always_comb
    begin
        offset_next = offset_reg;
        gain_next   = gain_reg;
        rows_next   = rows_reg;
        if (wr)
        begin
            case (idx)
                ntl_pkg::REG_ADC_OFFSET: offset_next = pwdata[ntl_pkg::OFFSET_W-1:0];
                ntl_pkg::REG_ADC_GAIN:   gain_next   = pwdata[ntl_pkg::GAIN_W-1:0];
                ntl_pkg::REG_TABLE_ROWS: rows_next   = pwdata[ntl_pkg::ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            ntl_pkg::REG_ADC_OFFSET: prdata = ntl_pkg::PDATA_W'(offset_reg);
            ntl_pkg::REG_ADC_GAIN:   prdata = ntl_pkg::PDATA_W'(gain_reg);
            ntl_pkg::REG_TABLE_ROWS: prdata = ntl_pkg::PDATA_W'(rows_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            gain_reg   <= ntl_pkg::GAIN_RESET;
            rows_reg   <= '0;
        end
        else
        begin
            offset_reg <= offset_next;
            gain_reg   <= gain_next;
            rows_reg   <= rows_next;
        end
    end

    assign cfg.adc_offset = offset_reg;
    assign cfg.adc_gain   = gain_reg;
    assign cfg.table_rows = rows_reg;

endmodule

// ----- rtl/core/ntc_thermistor_linearizer_top.sv -----
// Top level of the NTC thermistor linearizer: sequencer, datapath and output register.
//
// Usage:
//   in_ch (valid/ready) carries load and convert items. A load writes one row
//   (temperature, resistance) of the table in the transfer cycle and gives no
//   result. A convert corrects the ADC reading with offset and gain, scans the
//   table and interpolates where a segment brackets it; it gives one result on out_ch.
//   Configuration (offset, gain, row count) is to be written over the APB port
//   only while the block is idle (the block itself does not enforce this); pready is always high.
// Sequence:
//   A load is written in its transfer cycle. A convert passes through correction,
//   the resistance division on the shared 43-bit restoring divider (skipped when
//   the corrected value is not positive), the table scan, set-up and the
//   interpolation division (both only when a segment is found), and the load of
//   the output register. The block takes no new item until a convert is done;
//   in_ch.ready is high only between items.
// Reset: rst_n is asynchronous, active low; registers return to offset 0,
//   gain 1.0, zero rows. Table contents are undefined until loaded.
// Stall: the result sits in an output register; the next item is taken while
//   it waits, and a following convert holds in its last step until out_ch frees.
module ntc_thermistor_linearizer_top #(
    parameter int TABLE_DEPTH = ntl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ntl_in_if.sink                      in_ch,
    ntl_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ntl_pkg::PADDR_W-1:0] paddr,
    input  logic [ntl_pkg::PDATA_W-1:0] pwdata,
    output logic [ntl_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = ntl_pkg::DIV_NUM_W;
    localparam int VW = ntl_pkg::DIV_DEN_W;
    localparam int TW = ntl_pkg::TEMP_W;
    localparam int RW = ntl_pkg::RES_W;

    ntl_pkg::cfg_t     cfg;
    ntl_pkg::div_req_t div_req;
    ntl_pkg::div_rsp_t div_rsp;
    ntl_pkg::state_t   state_reg, state_next;

    // control strobes
    logic in_ready;
    logic take;
    logic tbl_wr;
    logic rd_en;
    logic ld_out;
    logic scan_done;
    logic n_le_zero;

    logic [CW-1:0] rows_lim;
    logic [CW-1:0] cnt_reg;
    logic          vld_reg;

    logic [ntl_pkg::READING_W-1:0] reading_reg;
    logic signed [30:0]            n_reg;
    logic [RW-1:0]                 r_reg;
    logic signed [TW-1:0]          prev_t_reg, t1_reg, t2_reg;
    logic [RW-1:0]                 prev_r_reg, r1_reg, r2_reg;
    logic                          found_reg;
    logic [40:0]                   prod_reg;
    logic [RW-1:0]                 den_reg;
    logic                          neg_reg;
    logic signed [TW-1:0]          temp_reg;

    logic                          out_valid_reg, out_valid_next;
    logic signed [TW-1:0]          out_temp_reg;
    logic [RW-1:0]                 out_res_reg;
    logic                          out_status_reg;

    logic signed [TW-1:0] rd_temp;
    logic [RW-1:0]        rd_res;

    // correction datapath
    logic [ntl_pkg::GAIN_W-1:0] g_eff;
    logic signed [17:0]         gdiff;
    logic signed [28:0]         prod_o;
    logic [22:0]                g125;
    logic [23:0]                g250;

    // interpolation datapath
    logic signed [16:0] tdiff;
    logic [16:0]        tmag;
    logic [RW-1:0]      rdelta;
    logic signed [19:0] qs;
    logic signed [19:0] tsum;
    logic signed [TW-1:0] tsat;

    ntl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ntl_table #(.DEPTH(TABLE_DEPTH)) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr),
        .wr_addr (AW'(in_ch.row_index)),
        .wr_temp (in_ch.row_temperature),
        .wr_res  (in_ch.row_resistance),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[AW-1:0]),
        .rd_temp (rd_temp),
        .rd_res  (rd_res)
    );

    ntl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign rows_lim  = (32'(cfg.table_rows) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                            : CW'(cfg.table_rows);
    assign scan_done = (cnt_reg >= rows_lim) && !vld_reg;
    assign n_le_zero = n_reg[30] || (n_reg == '0);
    assign take      = in_ch.valid && in_ready;

    always_comb
    begin
        g_eff  = (cfg.adc_gain == '0) ? ntl_pkg::GAIN_W'(1) : cfg.adc_gain;
        gdiff  = 18'sd32768 - $signed({2'b00, g_eff});
        prod_o = $signed({1'b0, cfg.adc_offset}) * gdiff;
        g125   = 23'(g_eff) * 23'd125;
        g250   = {g125, 1'b0};
        tdiff  = $signed({t1_reg[TW-1], t1_reg}) - $signed({t2_reg[TW-1], t2_reg});
        tmag   = tdiff[16] ? 17'(-tdiff) : 17'(tdiff);
        rdelta = r_reg - r2_reg;
        qs     = $signed({1'b0, div_rsp.quotient[18:0]});
        tsum   = 20'(t2_reg) + (neg_reg ? -qs : qs);
        if (tsum > 20'sd32767)
        begin
            tsat = 16'sh7FFF;
        end
        else if (tsum < -20'sd32768)
        begin
            tsat = -16'sh8000;
        end
        else
        begin
            tsat = tsum[TW-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ntl_pkg::S_IDLE:
            begin
                if (take && in_ch.operation == ntl_pkg::OP_CONVERT)
                begin
                    state_next = ntl_pkg::S_CORR;
                end
            end
            ntl_pkg::S_CORR:       state_next = ntl_pkg::S_RDIV_START;
            ntl_pkg::S_RDIV_START: state_next = n_le_zero ? ntl_pkg::S_SCAN
                                                          : ntl_pkg::S_RDIV_WAIT;
            ntl_pkg::S_RDIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ntl_pkg::S_SCAN;
                end
            end
            ntl_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = found_reg ? ntl_pkg::S_MUL : ntl_pkg::S_FIN;
                end
            end
            ntl_pkg::S_MUL:        state_next = ntl_pkg::S_IDIV_START;
            ntl_pkg::S_IDIV_START: state_next = ntl_pkg::S_IDIV_WAIT;
            ntl_pkg::S_IDIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ntl_pkg::S_FIN;
                end
            end
            ntl_pkg::S_FIN:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = ntl_pkg::S_IDLE;
                end
            end
            default:               state_next = ntl_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready         = 1'b0;
        tbl_wr           = 1'b0;
        rd_en            = 1'b0;
        ld_out           = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = NW'({n_reg[29:0], 4'b0000}) + NW'(g125);
        div_req.divisor  = VW'(g250);
        case (state_reg)
            ntl_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                tbl_wr   = in_ch.valid && in_ch.operation == ntl_pkg::OP_LOAD &&
                           (32'(in_ch.row_index) < TABLE_DEPTH);
            end
            ntl_pkg::S_RDIV_START:
            begin
                div_req.start = !n_le_zero;
            end
            ntl_pkg::S_SCAN:
            begin
                rd_en = cnt_reg < rows_lim;
            end
            ntl_pkg::S_IDIV_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = NW'({prod_reg, 1'b0}) + NW'(den_reg);
                div_req.divisor  = VW'({den_reg, 1'b0});
            end
            ntl_pkg::S_FIN:
            begin
                ld_out = !out_valid_reg || out_ch.ready;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ld_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ntl_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            vld_reg       <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            vld_reg       <= rd_en;
            if (state_reg == ntl_pkg::S_CORR)
            begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (rd_en)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (vld_reg && r_reg <= prev_r_reg && r_reg > rd_res)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ntl_pkg::S_IDLE:
            begin
                if (take)
                begin
                    reading_reg <= in_ch.adc_reading;
                end
            end
            ntl_pkg::S_CORR:
            begin
                n_reg      <= $signed({2'b00, reading_reg, 9'b0}) - 31'(prod_o);
                prev_t_reg <= ntl_pkg::START_TEMP;
                prev_r_reg <= ntl_pkg::START_RES;
            end
            ntl_pkg::S_RDIV_START:
            begin
                r_reg <= '0;
            end
            ntl_pkg::S_RDIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    r_reg <= (div_rsp.quotient[NW-1:RW] != '0) ? ntl_pkg::RES_MAX
                                                               : div_rsp.quotient[RW-1:0];
                end
            end
            ntl_pkg::S_SCAN:
            begin
                if (vld_reg)
                begin
                    // keep the last segment that brackets the resistance
                    if (r_reg <= prev_r_reg && r_reg > rd_res)
                    begin
                        t1_reg <= prev_t_reg;
                        t2_reg <= rd_temp;
                        r1_reg <= prev_r_reg;
                        r2_reg <= rd_res;
                    end
                    prev_t_reg <= rd_temp;
                    prev_r_reg <= rd_res;
                end
                temp_reg <= '0;
            end
            ntl_pkg::S_MUL:
            begin
                prod_reg <= 41'(tmag) * 41'(rdelta);
                den_reg  <= r1_reg - r2_reg;
                neg_reg  <= tdiff[16];
            end
            ntl_pkg::S_IDIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    temp_reg <= tsat;
                end
            end
            default: ;
        endcase
        if (ld_out)
        begin
            out_temp_reg   <= found_reg ? temp_reg : '0;
            out_res_reg    <= r_reg;
            out_status_reg <= found_reg ? ntl_pkg::ST_INTERPOLATED : ntl_pkg::ST_NO_SEGMENT;
        end
    end

    assign in_ch.ready        = in_ready;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.temperature = out_temp_reg;
    assign out_ch.resistance  = out_res_reg;
    assign out_ch.status      = out_status_reg;

`ifndef SYNTHESIS
    a_nosegment_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status == ntl_pkg::ST_NO_SEGMENT |-> out_ch.temperature == '0)
        else $error("no-segment result carries a nonzero temperature");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_segment_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ntl_pkg::S_MUL |-> r1_reg > r2_reg && r_reg > r2_reg && r_reg <= r1_reg)
        else $error("selected segment does not bracket the resistance");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.busy |-> !in_ch.ready)
        else $error("input accepted while a division runs");
`endif

endmodule

// ----- sim/tb.sv -----
// Testbench of the NTC thermistor linearizer: table loads, conversions, register settings.
module tb;
    localparam int OW    = ntl_pkg::OFFSET_W;
    localparam int GW    = ntl_pkg::GAIN_W;
    localparam int NRW   = ntl_pkg::ROWS_W;
    localparam int IW    = ntl_pkg::INDEX_W;
    localparam int TW    = ntl_pkg::TEMP_W;
    localparam int RW    = ntl_pkg::RES_W;
    localparam int RDW   = ntl_pkg::READING_W;
    localparam int PAW   = ntl_pkg::PADDR_W;
    localparam int PDW   = ntl_pkg::PDATA_W;
    localparam int DEPTH = ntl_pkg::TABLE_DEPTH_DEF;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [PAW-1:0] paddr;
    logic [PDW-1:0] pwdata;
    logic [PDW-1:0] prdata;
    logic pready;

    ntl_in_if  in_ch ();
    ntl_out_if out_ch ();

    ntc_thermistor_linearizer_top dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    typedef struct packed {
        logic signed [TW-1:0]     temperature;
        logic [RW-1:0]            resistance;
        ntl_pkg::status_t         status;
    } reading_t;

    // predictor state
    logic [OW-1:0]        cur_offset;
    logic [GW-1:0]        cur_gain;
    logic [NRW-1:0]       cur_rows;
    logic signed [TW-1:0] temp_rows [DEPTH];
    logic [RW-1:0]        res_rows  [DEPTH];

    reading_t pending_readings[$];
    int  mismatches;
    int  checked;
    int  converts_sent;
    int  loads_sent;
    longint cycles = 0;
    int  hold_off;       // cycles the receiver still refuses results
    bit  quiet_sink;     // no random stalls on the output side

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [RW-1:0] corrected_kohm(logic [RDW-1:0] a);
        longint g;
        longint n;
        longint r;
        g = (cur_gain == 0) ? 1 : longint'(cur_gain);
        n = longint'(a) * 512 - longint'(cur_offset) * (32768 - g);
        if (n <= 0)
            return '0;
        r = (n * 16 + 125 * g) / (250 * g);
        return (r > 16777215) ? ntl_pkg::RES_MAX : r[RW-1:0];
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag * 2 + den) / (den * 2);
        return (num < 0) ? -q : q;
    endfunction

    function automatic reading_t interpolate(logic [RDW-1:0] a);
        reading_t res;
        longint r, prev_r, r1, r2, t1, t2, prev_t, temp;
        int rows;
        bit found;
        r = corrected_kohm(a);
        rows = (int'(cur_rows) > DEPTH) ? DEPTH : int'(cur_rows);
        prev_r = ntl_pkg::START_RES;
        prev_t = ntl_pkg::START_TEMP;
        found = 0;
        r1 = 0; r2 = 0; t1 = 0; t2 = 0; temp = 0;
        for (int i = 0; i < rows; i++)
        begin
            if (r <= prev_r && r > longint'(res_rows[i]))
            begin
                t1 = prev_t; t2 = temp_rows[i]; r1 = prev_r; r2 = res_rows[i];
                found = 1;
            end
            prev_t = temp_rows[i];
            prev_r = res_rows[i];
        end
        if (found)
        begin
            temp = t2 + round_div((t1 - t2) * (r - r2), r1 - r2);
            if (temp > 32767) temp = 32767;
            if (temp < -32768) temp = -32768;
        end
        res.temperature = temp[TW-1:0];
        res.resistance = r[RW-1:0];
        res.status = found ? ntl_pkg::ST_INTERPOLATED : ntl_pkg::ST_NO_SEGMENT;
        return res;
    endfunction

    // result checker: sample at the rising edge
    initial
    begin
        reading_t want;
        reading_t got;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got.temperature = out_ch.temperature;
                got.resistance = out_ch.resistance;
                got.status = ntl_pkg::status_t'(out_ch.status);
                if (pending_readings.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result t=%0d r=%0d s=%0d",
                                 got.temperature, got.resistance, got.status);
                end
                else
                begin
                    want = pending_readings.pop_front();
                    checked++;
                    if (want !== got)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp t=%0d r=%0d s=%0d got t=%0d r=%0d s=%0d",
                                     want.temperature, want.resistance, want.status,
                                     got.temperature, got.resistance, got.status);
                    end
                end
            end
        end
    end

    // receiver: stall at random, count long hold-offs down cycle by cycle
    initial
    begin
        int gap;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                hold_off--;
                out_ch.ready <= 1'b0;
            end
            else if (quiet_sink)
                out_ch.ready <= 1'b1;
            else
            begin
                gap = $urandom_range(0, 99);
                if (gap == 0)
                begin
                    hold_off = $urandom_range(20, 200);
                    out_ch.ready <= 1'b0;
                end
                else
                    out_ch.ready <= (gap < 70);
            end
        end
    end

    task automatic sender_gap(bit no_gaps);
        int g;
        if (no_gaps)
            return;
        g = $urandom_range(0, 99);
        if (g < 60)
            return;
        in_ch.valid <= 1'b0;
        repeat ((g < 95) ? $urandom_range(1, 3) : $urandom_range(10, 150)) @(negedge clk);
    endtask

    // drive one item; valid stays up on return so the next one can follow at once
    task automatic send_item(ntl_pkg::op_t op, logic [IW-1:0] idx, logic signed [TW-1:0] tv,
                             logic [RW-1:0] rv, logic [RDW-1:0] a, bit no_gaps = 0);
        sender_gap(no_gaps);
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.row_index <= idx;
        in_ch.row_temperature <= tv;
        in_ch.row_resistance <= rv;
        in_ch.adc_reading <= a;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (op == ntl_pkg::OP_LOAD)
        begin
            temp_rows[idx] = tv;
            res_rows[idx] = rv;
            loads_sent++;
        end
        else
        begin
            pending_readings.insert(pending_readings.size(), interpolate(a));
            converts_sent++;
        end
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
        // let the output side settle
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(ntl_pkg::reg_index_t idx, logic [PDW-1:0] value);
        in_ch.valid <= 1'b0;
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= PAW'(4 * int'(idx)); pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            ntl_pkg::REG_ADC_OFFSET: cur_offset = value[OW-1:0];
            ntl_pkg::REG_ADC_GAIN:   cur_gain = value[GW-1:0];
            ntl_pkg::REG_TABLE_ROWS: cur_rows = value[NRW-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // descending resistance table, rising temperatures, a few flat or odd rows
    task automatic load_table(int rows, bit no_gaps = 0);
        logic [RW-1:0] res;
        logic signed [TW-1:0] tv;
        res = ntl_pkg::RES_MAX - RW'($urandom_range(0, 100000));
        tv = ntl_pkg::START_TEMP;
        for (int i = 0; i < rows; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(ntl_pkg::OP_LOAD, IW'(i), TW'($urandom), RW'($urandom),
                          RDW'($urandom), no_gaps);
            else
            begin
                res = (res > RW'(300000)) ? res - RW'($urandom_range(0, res / 4)) : res / 2;
                tv = tv + TW'($urandom_range(0, 2000));
                send_item(ntl_pkg::OP_LOAD, IW'(i), tv, res, RDW'($urandom), no_gaps);
            end
        end
    endtask

    function automatic logic [RDW-1:0] pick_reading();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return RDW'($urandom_range(0, 4000));
            default: return RDW'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        write_reg(ntl_pkg::REG_ADC_OFFSET, 0);
        write_reg(ntl_pkg::REG_ADC_GAIN, 16384);
        load_table(4);
        send_item(ntl_pkg::OP_LOAD, IW'(4), 16'sh7FFF, 24'd0, '0);
        send_item(ntl_pkg::OP_LOAD, IW'(5), -16'sh8000, ntl_pkg::RES_MAX, '0);
        write_reg(ntl_pkg::REG_TABLE_ROWS, 0);
        send_item(ntl_pkg::OP_CONVERT, '0, '0, '0, 20'd1000);
        drain();
        write_reg(ntl_pkg::REG_TABLE_ROWS, 6);
        send_item(ntl_pkg::OP_CONVERT, '0, '0, '0, 20'd0);
        send_item(ntl_pkg::OP_CONVERT, '0, '0, '0, 20'hFFFFF);
        send_item(ntl_pkg::OP_CONVERT, '0, '0, '0, 20'd342);
        send_item(ntl_pkg::OP_CONVERT, '0, '0, '0, 20'd55555);
        send_item(ntl_pkg::OP_CONVERT, '0, '0, '0, 20'd1);
        drain();
        // negative corrected value and gain extremes
        write_reg(ntl_pkg::REG_ADC_OFFSET, 1023);
        write_reg(ntl_pkg::REG_ADC_GAIN, 1);
        send_item(ntl_pkg::OP_CONVERT, '0, '0, '0, 20'd10);
        send_item(ntl_pkg::OP_CONVERT, '0, '0, '0, 20'hFFFFF);
        drain();
        write_reg(ntl_pkg::REG_ADC_GAIN, 0);
        send_item(ntl_pkg::OP_CONVERT, '0, '0, '0, 20'd70000);
        drain();
        write_reg(ntl_pkg::REG_ADC_GAIN, 65535);
        write_reg(ntl_pkg::REG_UNUSED, 32'hFFFF_FFFF);
        send_item(ntl_pkg::OP_CONVERT, '0, '0, '0, 20'hFFFFF);
        send_item(ntl_pkg::OP_CONVERT, '0, '0, '0, 20'd3000);
        drain();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 8; ph++)
        begin
            int rows;
            rows = (ph == 0) ? 64 : (ph == 1) ? 1 : $urandom_range(2, 20);
            write_reg(ntl_pkg::REG_ADC_OFFSET, (ph == 2) ? 1023 : $urandom_range(0, 1023));
            write_reg(ntl_pkg::REG_ADC_GAIN,
                      (ph == 3) ? 65535 : (ph == 4) ? 1 : $urandom_range(4000, 40000));
            write_reg(ntl_pkg::REG_TABLE_ROWS, 0);
            load_table(rows);
            drain();
            write_reg(ntl_pkg::REG_TABLE_ROWS, (ph == 0) ? 127 : rows);
            for (int k = 0; k < 90; k++)
            begin
                int ri;
                ri = $urandom_range(0, 9);
                // reload only rows already valid, so no unwritten row is read
                if (ri == 0)
                    send_item(ntl_pkg::OP_LOAD, IW'($urandom_range(0, rows - 1)),
                              TW'($urandom), RW'($urandom), RDW'($urandom));
                else
                    send_item(ntl_pkg::OP_CONVERT, IW'($urandom), TW'($urandom),
                              RW'($urandom), pick_reading());
            end
            drain();
        end
    endtask

    task automatic test_backpressure();
        hold_off = 600;
        for (int k = 0; k < 6; k++)
            send_item(ntl_pkg::OP_CONVERT, IW'($urandom), TW'($urandom), RW'($urandom),
                      pick_reading(), 1);
        drain();
        // sender waits for every result before each next item
        quiet_sink = 1;
        for (int k = 0; k < 10; k++)
        begin
            send_item(ntl_pkg::OP_CONVERT, '0, '0, '0, pick_reading(), 1);
            in_ch.valid <= 1'b0;
            while (pending_readings.size() != 0)
                @(negedge clk);
        end
        quiet_sink = 0;
        drain();
    endtask

    initial
    begin
        mismatches = 0;
        checked = 0;
        converts_sent = 0;
        loads_sent = 0;
        hold_off = 0;
        quiet_sink = 0;
        cur_offset = '0;
        cur_gain = ntl_pkg::GAIN_RESET;
        cur_rows = '0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.operation = ntl_pkg::OP_LOAD;
        in_ch.row_index = '0;
        in_ch.row_temperature = '0;
        in_ch.row_resistance = '0;
        in_ch.adc_reading = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random_phases();
        test_backpressure();
        drain();
        $display("covered %0d loads and %0d conversions, %0d results checked",
                 loads_sent, converts_sent, checked);
        $display("register sweeps over offset, gain and row count extremes, with stalls");
        if (mismatches == 0 && pending_readings.size() == 0)
            $display("TB_OK");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_readings.size());
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
